/* hw/rtl/egsc_pkg.sv */
// Shared types, constants and pipeline depths for the exposure/gain converter.
// No dependencies; every other file but egsc_cfg_if imports this package.
package egsc_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 24;
  localparam int TQ_W           = GAIN_FRAC_BITS + 5;  // gain clamped to 16.0

  localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_LOW_MAX = GAIN_W'(16) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_TOP     = GAIN_W'(92) << GAIN_FRAC_BITS;

  localparam logic [31:0] TIME_MIN_NS = 32'd37516;
  localparam logic [31:0] TIME_MAX_NS = 32'd66666664;
  localparam logic [29:0] NS_PER_S    = 30'd1000000000;

  localparam logic [10:0] ANALOG_SCALE = 11'd1024;
  localparam logic [11:0] DIGITAL_ONE  = 12'd256;
  localparam logic [11:0] DIGITAL_CAP  = 12'd3840;

  // divider quotient widths, one bit per stage
  localparam int LDIV_QW = 18;  // top bit flags line overflow
  localparam int ADIV_QW = 11;
  localparam int IDIV_QW = 24;

  localparam int LINE_CORE_LAT = 1 + LDIV_QW + 2;
  localparam int PIPE_LAT      = 1 + ADIV_QW + 3 + IDIV_QW;
  localparam int LINE_PAD      = PIPE_LAT - LINE_CORE_LAT;

  // configuration register indexes
  localparam logic [2:0] REG_PIXEL_CLOCK  = 3'd0;
  localparam logic [2:0] REG_LINE_LENGTH  = 3'd1;
  localparam logic [2:0] REG_FRAME_LINES  = 3'd2;
  localparam logic [2:0] REG_ACTIVE_H     = 3'd3;
  localparam logic [2:0] REG_VERT_OFFSET  = 3'd4;
  localparam logic [2:0] REG_MIN_LINES    = 3'd5;
  localparam logic [2:0] REG_ANALOG_MAX   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_GAIN = 2'd1,
    ST_TIME = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] pclk;
    logic [45:0] den;   // line length (zero taken as one) times 1e9
    logic [15:0] dfl;
    logic [15:0] ah;
    logic [7:0]  voff;
    logic [7:0]  minl;
    logic [9:0]  acm;
  } cfg_t;

  typedef struct packed {
    logic [15:0] integ_lines;
    logic [15:0] frame_len_lines;
    logic [15:0] vblank_lines;
  } line_res_t;

  typedef struct packed {
    logic [9:0]        analog_gain_code;
    logic [11:0]       dgain_code;
    logic [GAIN_W-1:0] isp_gain_q16;
  } gain_res_t;

endpackage

/* hw/rtl/egsc_in_if.sv */
// Request channel: exposure time and total gain.
// Depends on egsc_pkg.
interface egsc_in_if;
  import egsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [31:0]       exposure_ns;
  logic [GAIN_W-1:0] gain_q16;
  modport source (output valid, exposure_ns, gain_q16, input ready);
  modport sink   (input valid, exposure_ns, gain_q16, output ready);
endinterface

/* hw/rtl/egsc_out_if.sv */
// Result channel: sensor controls and status.
// Depends on egsc_pkg.
interface egsc_out_if;
  import egsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [15:0]       integ_lines;
  logic [15:0]       frame_len_lines;
  logic [15:0]       vblank_lines;
  logic [15:0]       integ_lines_even;
  logic [9:0]        analog_gain_code;
  logic [11:0]       dgain_code;
  logic [GAIN_W-1:0] isp_gain_q16;
  modport source (output valid, status, integ_lines, frame_len_lines, vblank_lines,
                  integ_lines_even, analog_gain_code, dgain_code, isp_gain_q16,
                  input ready);
  modport sink   (input valid, status, integ_lines, frame_len_lines, vblank_lines,
                  integ_lines_even, analog_gain_code, dgain_code, isp_gain_q16,
                  output ready);
endinterface

/* hw/rtl/egsc_cfg_if.sv */
// Configuration write channel: register index and data.
// No package dependency.
interface egsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/egsc_cfg_regs.sv */
// Configuration register bank plus the registered line divisor.
// Depends on egsc_pkg and egsc_cfg_if.
module egsc_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  egsc_cfg_if.sink        cfg_ch,
  output egsc_pkg::cfg_t  cfg
);
  import egsc_pkg::*;

  logic [31:0] pclk_r;
  logic [15:0] ll_r;
  logic [15:0] dfl_r;
  logic [15:0] ah_r;
  logic [7:0]  voff_r;
  logic [7:0]  minl_r;
  logic [9:0]  acm_r;
  logic [45:0] den_r;
  logic [15:0] ll_eff;
  logic        wr;

  assign cfg_ch.ready = 1'b1;
  assign wr     = cfg_ch.valid;
  assign ll_eff = (ll_r == 16'd0) ? 16'd1 : ll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pclk_r <= 32'd719898240;
      ll_r   <= 16'd6752;
      dfl_r  <= 16'd3554;
      ah_r   <= 16'd2160;
      voff_r <= 8'd8;
      minl_r <= 8'd4;
      acm_r  <= 10'd960;
    end else if (wr) begin
      case (cfg_ch.index)
        REG_PIXEL_CLOCK: pclk_r <= cfg_ch.data;
        REG_LINE_LENGTH: ll_r   <= cfg_ch.data[15:0];
        REG_FRAME_LINES: dfl_r  <= cfg_ch.data[15:0];
        REG_ACTIVE_H:    ah_r   <= cfg_ch.data[15:0];
        REG_VERT_OFFSET: voff_r <= cfg_ch.data[7:0];
        REG_MIN_LINES:   minl_r <= cfg_ch.data[7:0];
        REG_ANALOG_MAX:  acm_r  <= cfg_ch.data[9:0];
        default: ;
      endcase
    end
  end

  // divisor is registered from the stored line length, so it lags the line length register
  always_ff @(posedge clk) begin
    den_r <= 46'(ll_eff) * 46'(NS_PER_S);
  end

  assign cfg = '{pclk: pclk_r, den: den_r, dfl: dfl_r, ah: ah_r,
                 voff: voff_r, minl: minl_r, acm: acm_r};
endmodule

/* hw/rtl/egsc_line_path.sv */
// Line count, frame length and vertical blanking: multiply, bit-per-stage
// divide, round/clamp, frame stage, then a delay to the common depth. Uses egsc_pkg.
module egsc_line_path (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          exposure_ns,
  input  egsc_pkg::cfg_t       cfg,
  output egsc_pkg::line_res_t  res
);
  import egsc_pkg::*;

  logic [63:0]        rem_r [0:LDIV_QW];
  logic [LDIV_QW-1:0] q_r   [0:LDIV_QW];
  logic [63:0]        dsh   [0:LDIV_QW-1];
  logic [15:0]        lines_r;
  line_res_t          core_r;
  line_res_t          pad_r [0:LINE_PAD-1];

  logic        rnd;
  logic [18:0] qr;
  logic [18:0] qmin;
  logic [15:0] lines_nxt;
  logic [16:0] sum;
  logic [15:0] frame_nxt;

  always_comb begin
    for (int i = 0; i < LDIV_QW; i++) begin
      dsh[i] = {18'b0, cfg.den} << (LDIV_QW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {32'b0, exposure_ns} * {32'b0, cfg.pclk};
      q_r[0]   <= '0;
      for (int i = 0; i < LDIV_QW; i++) begin
        if (rem_r[i] >= dsh[i]) begin
          rem_r[i+1] <= rem_r[i] - dsh[i];
          q_r[i+1]   <= q_r[i] | (LDIV_QW'(1) << (LDIV_QW - 1 - i));
        end else begin
          rem_r[i+1] <= rem_r[i];
          q_r[i+1]   <= q_r[i];
        end
      end
    end
  end

  // round half up on the remainder, floor at min_lines, saturate
  always_comb begin
    rnd  = {rem_r[LDIV_QW], 1'b0} >= {19'b0, cfg.den};
    qr   = 19'(q_r[LDIV_QW]) + 19'(rnd);
    qmin = (qr < 19'(cfg.minl)) ? 19'(cfg.minl) : qr;
    if (q_r[LDIV_QW][LDIV_QW-1] || qmin > 19'hFFFF) begin
      lines_nxt = 16'hFFFF;
    end else begin
      lines_nxt = qmin[15:0];
    end
  end

  always_comb begin
    sum = 17'(lines_r) + 17'(cfg.voff);
    if (sum > 17'(cfg.dfl)) begin
      frame_nxt = sum[16] ? 16'hFFFF : sum[15:0];
    end else begin
      frame_nxt = cfg.dfl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lines_r <= lines_nxt;
      core_r  <= '{integ_lines: lines_r, frame_len_lines: frame_nxt,
                   vblank_lines: frame_nxt - cfg.ah};
      pad_r[0] <= core_r;
      for (int k = 1; k < LINE_PAD; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  assign res = pad_r[LINE_PAD-1];
endmodule

/* hw/rtl/egsc_gain_path.sv */
// Gain split: analog code by pipelined ceil-divide, digital code by multiply,
// residual gain by a second pipelined divide. Uses egsc_pkg.
module egsc_gain_path (
  input  logic                 clk,
  input  logic                 en,
  input  logic [egsc_pkg::GAIN_W-1:0] gain_q16,
  input  egsc_pkg::cfg_t       cfg,
  output egsc_pkg::gain_res_t  res
);
  import egsc_pkg::*;

  localparam int AREM_W = 11 + GAIN_FRAC_BITS + 1;
  localparam int ASH_W  = TQ_W + ADIV_QW;
  localparam int PROD_W = GAIN_W + 11;
  localparam int IREM_W = PROD_W + 2;
  localparam int ISH_W  = 15 + IDIV_QW;

  // analog divider stages
  logic [AREM_W-1:0]  arem_r [0:ADIV_QW];
  logic [ADIV_QW-1:0] aq_r   [0:ADIV_QW];
  logic [TQ_W-1:0]    atq_r  [0:ADIV_QW];
  logic [GAIN_W-1:0]  ag_r   [0:ADIV_QW];
  logic               ahi_r  [0:ADIV_QW];
  logic [ASH_W-1:0]   ash    [0:ADIV_QW-1];

  logic [9:0]         code_r;
  logic [10:0]        m_r;
  logic [GAIN_W-1:0]  g13_r;
  logic               hi13_r;
  logic [PROD_W-1:0]  prod_r;
  logic [9:0]         code14_r;
  logic               hi14_r;

  // residual divider stages
  logic [IREM_W-1:0]  irem_r [0:IDIV_QW];
  logic [14:0]        idiv_r [0:IDIV_QW];
  logic [IDIV_QW-1:0] iq_r   [0:IDIV_QW];
  logic [9:0]         ic_r   [0:IDIV_QW];
  logic [11:0]        id_r   [0:IDIV_QW];
  logic [ISH_W-1:0]   ish    [0:IDIV_QW-1];

  logic [TQ_W-1:0]    tq;
  logic [10:0]        code11;
  logic [9:0]         code_nxt;
  logic [16:0]        dq;
  logic [11:0]        dcode_nxt;

  assign tq = (gain_q16 > GAIN_LOW_MAX) ? TQ_W'(GAIN_LOW_MAX) : gain_q16[TQ_W-1:0];

  always_comb begin
    for (int i = 0; i < ADIV_QW; i++) begin
      ash[i] = ASH_W'(atq_r[i]) << (ADIV_QW - 1 - i);
    end
    for (int i = 0; i < IDIV_QW; i++) begin
      ish[i] = ISH_W'(idiv_r[i]) << (IDIV_QW - 1 - i);
    end
  end

  // ceil(1024/t) = floor((1024*one + t - 1) / t)
  always_ff @(posedge clk) begin
    if (en) begin
      arem_r[0] <= (AREM_W'(ANALOG_SCALE) << GAIN_FRAC_BITS) + AREM_W'(tq) - AREM_W'(1);
      aq_r[0]   <= '0;
      atq_r[0]  <= tq;
      ag_r[0]   <= gain_q16;
      ahi_r[0]  <= gain_q16 > GAIN_LOW_MAX;
      for (int i = 0; i < ADIV_QW; i++) begin
        if (ASH_W'(arem_r[i]) >= ash[i]) begin
          arem_r[i+1] <= arem_r[i] - ash[i][AREM_W-1:0];
          aq_r[i+1]   <= aq_r[i] | (ADIV_QW'(1) << (ADIV_QW - 1 - i));
        end else begin
          arem_r[i+1] <= arem_r[i];
          aq_r[i+1]   <= aq_r[i];
        end
        atq_r[i+1] <= atq_r[i];
        ag_r[i+1]  <= ag_r[i];
        ahi_r[i+1] <= ahi_r[i];
      end
    end
  end

  always_comb begin
    code11   = ANALOG_SCALE - aq_r[ADIV_QW];
    code_nxt = (code11 > 11'(cfg.acm)) ? cfg.acm : code11[9:0];
  end

  always_comb begin
    dq = prod_r[PROD_W-1:GAIN_FRAC_BITS+2];
    if (!hi14_r) begin
      dcode_nxt = DIGITAL_ONE;
    end else if (dq > 17'(DIGITAL_CAP)) begin
      dcode_nxt = DIGITAL_CAP;
    end else begin
      dcode_nxt = dq[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r   <= code_nxt;
      m_r      <= ANALOG_SCALE - 11'(code_nxt);
      g13_r    <= ag_r[ADIV_QW];
      hi13_r   <= ahi_r[ADIV_QW];
      prod_r   <= PROD_W'(g13_r) * PROD_W'(m_r);
      code14_r <= code_r;
      hi14_r   <= hi13_r;
      // isp = (2*prod + 4*d) / (8*d)
      irem_r[0] <= IREM_W'({prod_r, 1'b0}) + IREM_W'({dcode_nxt, 2'b00});
      idiv_r[0] <= {dcode_nxt, 3'b000};
      iq_r[0]   <= '0;
      ic_r[0]   <= code14_r;
      id_r[0]   <= dcode_nxt;
      for (int i = 0; i < IDIV_QW; i++) begin
        if (ISH_W'(irem_r[i]) >= ish[i]) begin
          irem_r[i+1] <= irem_r[i] - ish[i][IREM_W-1:0];
          iq_r[i+1]   <= iq_r[i] | (IDIV_QW'(1) << (IDIV_QW - 1 - i));
        end else begin
          irem_r[i+1] <= irem_r[i];
          iq_r[i+1]   <= iq_r[i];
        end
        idiv_r[i+1] <= idiv_r[i];
        ic_r[i+1]   <= ic_r[i];
        id_r[i+1]   <= id_r[i];
      end
    end
  end

  assign res = '{analog_gain_code: ic_r[IDIV_QW], dgain_code: id_r[IDIV_QW],
                 isp_gain_q16: iq_r[IDIV_QW]};
endmodule

/* hw/rtl/exposure_gain_to_sensor_controls.sv */
// Exposure/gain to sensor controls. Throughput: one request per cycle; the whole
// pipeline holds while the output register waits on out_ch.ready. Reset (rst_n
// low, synchronous) clears the valid chain and restores register defaults; no
// clearing pass.
module exposure_gain_to_sensor_controls (
  input  logic       clk,
  input  logic       rst_n,
  egsc_in_if.sink    in_ch,
  egsc_out_if.source out_ch,
  egsc_cfg_if.sink   cfg_ch
);
  import egsc_pkg::*;

  cfg_t      cfg;
  line_res_t line_res;
  gain_res_t gain_res;

  // one enable for every stage: move when the output slot is free or draining
  logic      en;
  logic      vld_r  [1:PIPE_LAT];
  status_t   stat_r [1:PIPE_LAT];
  status_t   stat_in;

  logic              out_valid_r;
  status_t           out_status_r;
  line_res_t         out_line_r;
  gain_res_t         out_gain_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  egsc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  egsc_line_path u_line (
    .clk         (clk),
    .en          (en),
    .exposure_ns (in_ch.exposure_ns),
    .cfg         (cfg),
    .res         (line_res)
  );

  egsc_gain_path u_gain (
    .clk      (clk),
    .en       (en),
    .gain_q16 (in_ch.gain_q16),
    .cfg      (cfg),
    .res      (gain_res)
  );

  // range checks: gain first, then exposure time
  always_comb begin
    if (in_ch.gain_q16 < GAIN_ONE || in_ch.gain_q16 > GAIN_TOP) begin
      stat_in = ST_GAIN;
    end else if (in_ch.exposure_ns < TIME_MIN_NS || in_ch.exposure_ns > TIME_MAX_NS) begin
      stat_in = ST_TIME;
    end else begin
      stat_in = ST_OK;
    end
  end

  // valid and status ride alongside the datapath stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= PIPE_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_ch.valid;
      for (int k = 2; k <= PIPE_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[PIPE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stat_r[1] <= stat_in;
      for (int k = 2; k <= PIPE_LAT; k++) begin
        stat_r[k] <= stat_r[k-1];
      end
      out_status_r <= stat_r[PIPE_LAT];
      // a rejected request reports zeros in every control field
      if (stat_r[PIPE_LAT] == ST_OK) begin
        out_line_r <= line_res;
        out_gain_r <= gain_res;
      end else begin
        out_line_r <= '0;
        out_gain_r <= '0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.integ_lines      = out_line_r.integ_lines;
  assign out_ch.frame_len_lines  = out_line_r.frame_len_lines;
  assign out_ch.vblank_lines     = out_line_r.vblank_lines;
  assign out_ch.integ_lines_even = {out_line_r.integ_lines[15:1], 1'b0};
  assign out_ch.analog_gain_code = out_gain_r.analog_gain_code;
  assign out_ch.dgain_code       = out_gain_r.dgain_code;
  assign out_ch.isp_gain_q16     = out_gain_r.isp_gain_q16;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |->
      out_line_r == '0 && out_gain_r == '0)
    else $error("rejected request carries nonzero controls");

  a_frame_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |->
      out_line_r.frame_len_lines >= out_line_r.integ_lines)
    else $error("frame shorter than integration lines");

  a_dcode_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |->
      out_gain_r.dgain_code <= DIGITAL_CAP &&
      out_gain_r.dgain_code >= DIGITAL_ONE)
    else $error("digital code outside range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[1])
    else $error("accepted request not in first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[PIPE_LAT]) && $stable(stat_r[PIPE_LAT]))
    else $error("pipeline moved during stall");
endmodule

/* tb/tb_exposure_gain_to_sensor_controls.sv */
// Testbench for the exposure/gain to sensor controls converter.
// Depends on egsc_pkg, the three channel interfaces and the converter RTL.
`timescale 1ns / 1ps

module tb_exposure_gain_to_sensor_controls;
  import egsc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  egsc_in_if  in_ch ();
  egsc_out_if out_ch ();
  egsc_cfg_if cfg_ch ();

  exposure_gain_to_sensor_controls dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // one expected result, same layout as the output channel payload
  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       integ_lines;
    logic [15:0]       frame_len_lines;
    logic [15:0]       vblank_lines;
    logic [15:0]       integ_lines_even;
    logic [9:0]        analog_gain_code;
    logic [11:0]       dgain_code;
    logic [GAIN_W-1:0] isp_gain_q16;
  } controls_t;

  controls_t pending_controls[$];

  // shadow copy of the converter registers
  logic [31:0] sh_pclk;
  logic [15:0] sh_line_len, sh_frame_lines, sh_active_h;
  logic [7:0]  sh_voff, sh_min_lines;
  logic [9:0]  sh_acm;

  int  mismatches = 0;
  int  cycles = 0;
  localparam int CYCLE_LIMIT = 400000;

  // stimulus pacing
  int  burst_left = 0;

  function automatic controls_t compute_controls(logic [31:0] t_ns, logic [23:0] gq);
    controls_t   c;
    logic [63:0] ll, num, den, q, r, lines, frame, tq, code, dcode, isp, prod;
    logic [63:0] one;
    one = 64'd1 << GAIN_FRAC_BITS;
    c = '0;
    if (gq < one || gq > 92 * one) begin
      c.status = ST_GAIN;
      return c;
    end
    if (t_ns < TIME_MIN_NS || t_ns > TIME_MAX_NS) begin
      c.status = ST_TIME;
      return c;
    end
    ll = (sh_line_len == 0) ? 64'd1 : 64'(sh_line_len);
    num = 64'(t_ns) * 64'(sh_pclk);
    den = ll * 64'd1000000000;
    q = num / den;
    r = num % den;
    if (2 * r >= den) q = q + 1;
    lines = (q < sh_min_lines) ? 64'(sh_min_lines) : q;
    if (lines > 64'hFFFF) lines = 64'hFFFF;
    frame = 64'(sh_frame_lines);
    if (lines + sh_voff > sh_frame_lines) begin
      frame = lines + sh_voff;
      if (frame > 64'hFFFF) frame = 64'hFFFF;
    end
    // analog code: 1024 - ceil(1024/t), t clamped to 16
    tq = (gq > 16 * one) ? 16 * one : 64'(gq);
    code = 1024 - ((1024 * one + tq - 1) / tq);
    if (code > sh_acm) code = 64'(sh_acm);
    prod = 64'(gq) * (1024 - code);
    if (gq <= 16 * one) dcode = 256;
    else begin
      dcode = prod / (4 * one);
      if (dcode > 3840) dcode = 3840;
    end
    if (dcode == 0) isp = 64'hFFFFFF;
    else isp = (2 * prod + 4 * dcode) / (8 * dcode);
    if (isp > 64'hFFFFFF) isp = 64'hFFFFFF;
    c.status           = ST_OK;
    c.integ_lines      = lines[15:0];
    c.frame_len_lines  = frame[15:0];
    c.vblank_lines     = frame[15:0] - sh_active_h;
    c.integ_lines_even = lines[15:0] & 16'hFFFE;
    c.analog_gain_code = code[9:0];
    c.dgain_code       = dcode[11:0];
    c.isp_gain_q16     = isp[23:0];
    return c;
  endfunction

  // drive a request at the falling edge, hold until accepted; valid stays up
  // for a following request and is dropped by a gap or by drain_all
  task automatic send_request(logic [31:0] t_ns, logic [23:0] gq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.exposure_ns <= t_ns;
    in_ch.gain_q16    <= gq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_controls.push_back(compute_controls(t_ns, gq));
    @(negedge clk);
  endtask

  // wait until every expected request has drained, then pipeline slack
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (pending_controls.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_PIXEL_CLOCK: sh_pclk        = val;
      REG_LINE_LENGTH: sh_line_len    = val[15:0];
      REG_FRAME_LINES: sh_frame_lines = val[15:0];
      REG_ACTIVE_H:    sh_active_h    = val[15:0];
      REG_VERT_OFFSET: sh_voff        = val[7:0];
      REG_MIN_LINES:   sh_min_lines   = val[7:0];
      REG_ANALOG_MAX:  sh_acm         = val[9:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(logic [31:0] pclk, logic [15:0] llen, logic [15:0] dfl,
                             logic [15:0] ah, logic [7:0] voff, logic [7:0] minl,
                             logic [9:0] acm);
    write_reg(REG_PIXEL_CLOCK, pclk);
    write_reg(REG_LINE_LENGTH, 32'(llen));
    write_reg(REG_FRAME_LINES, 32'(dfl));
    write_reg(REG_ACTIVE_H, 32'(ah));
    write_reg(REG_VERT_OFFSET, 32'(voff));
    write_reg(REG_MIN_LINES, 32'(minl));
    write_reg(REG_ANALOG_MAX, 32'(acm));
    cfg_ch.valid <= 1'b0;
  endtask

  // random gain, biased to the valid range and the 16.0 split point
  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 32'h1_0000));
      2:       return 24'($urandom_range(32'h5B_0000, 32'h5D_0000));
      3:       return 24'($urandom_range(32'hF_F000, 32'h10_1000));
      default: return 24'($urandom_range(32'h1_0000, 32'h5C_0000));
    endcase
  endfunction

  function automatic logic [31:0] rand_exposure();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(37000, 38000);
      2:       return $urandom_range(66666000, 66667000);
      3:       return $urandom_range(37516, 200000);
      default: return $urandom_range(37516, 66666664);
    endcase
  endfunction

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) send_request(rand_exposure(), rand_gain());
  endtask

  // directed: field extremes, both error checks, range edges, gain split
  task automatic test_directed();
    send_request(32'd0, 24'd0);
    send_request(32'hFFFF_FFFF, 24'hFF_FFFF);
    send_request(32'd1000000, 24'h00_FFFF);
    send_request(32'd1000000, 24'h5C_0001);
    send_request(32'd1000000, 24'h5C_0000);
    send_request(32'd1000000, 24'h01_0000);
    send_request(32'd37515, 24'h02_0000);
    send_request(32'd37516, 24'h02_0000);
    send_request(32'd66666664, 24'h02_0000);
    send_request(32'd66666665, 24'h02_0000);
    send_request(32'd0, 24'h5D_0000);      // gain error takes priority
    send_request(32'd5000000, 24'h10_0000);
    send_request(32'd5000000, 24'h10_0001);
    send_request(32'd5000000, 24'h20_0000);
    send_request(32'd5000000, 24'h01_8000);
    send_request(32'd33333333, 24'h03_0000);
    drain_all();
  endtask

  task automatic test_reset_config();
    random_requests(210);
    drain_all();
  endtask

  // zero line length, huge clock: line count and frame length saturate
  task automatic test_saturation();
    load_config(32'hFFFF_FFFF, 16'd0, 16'd1, 16'hFFFF, 8'hFF, 8'hFF, 10'h3FF);
    send_request(32'd66666664, 24'h5C_0000);
    send_request(32'd37516, 24'h10_0000);
    random_requests(150);
    drain_all();
  endtask

  // tiny clock: min_lines floor, zero analog cap, zero offset
  task automatic test_low_extremes();
    load_config(32'd1, 16'hFFFF, 16'hFFFF, 16'd1, 8'd0, 8'd1, 10'd0);
    send_request(32'd37516, 24'h01_0000);
    random_requests(150);
    drain_all();
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 6; k++) begin
      load_config($urandom_range(1_000_000, 32'hFFFF_FFFF), 16'($urandom_range(0, 65535)),
                  16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
                  10'($urandom));
      random_requests(120);
      drain_all();
    end
    // back to nominal timing for the tail
    load_config(32'd719898240, 16'd6752, 16'd3554, 16'd2160, 8'd8, 8'd4, 10'd960);
    random_requests(100);
  endtask

  // receiver stall pattern: long ready stretches mixed with random stalls
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_phase[9]) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    controls_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.integ_lines, out_ch.frame_len_lines,
              out_ch.vblank_lines, out_ch.integ_lines_even, out_ch.analog_gain_code,
              out_ch.dgain_code, out_ch.isp_gain_q16};
      if (pending_controls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_controls.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_exposure_gain_to_sensor_controls: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.exposure_ns = '0;
    in_ch.gain_q16 = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    sh_pclk = 32'd719898240;
    sh_line_len = 16'd6752;
    sh_frame_lines = 16'd3554;
    sh_active_h = 16'd2160;
    sh_voff = 8'd8;
    sh_min_lines = 8'd4;
    sh_acm = 10'd960;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_reset_config();
    test_saturation();
    test_low_extremes();
    test_random_configs();
    drain_all();
    if (mismatches == 0 && pending_controls.size() == 0)
      $display("tb_exposure_gain_to_sensor_controls: done, clean");
    else
      $display("tb_exposure_gain_to_sensor_controls: done, errors");
    $finish;
  end
endmodule
